FILE: rtl/core/xcsd_pkg.sv
package xcsd_pkg;

  // Framing characters
  localparam logic [7:0] CharStart = 8'h24;  // '$'
  localparam logic [7:0] CharCheck = 8'h2A;  // '*'
  localparam logic [7:0] CharEnd   = 8'h0A;  // newline
  localparam logic [7:0] CharComma = 8'h2C;  // ','
  localparam logic [7:0] CharMinus = 8'h2D;  // '-'
  localparam logic [7:0] CharPlus  = 8'h2B;  // '+'
  localparam logic [7:0] CharSpace = 8'h20;  // ' '
  localparam logic [7:0] CharTab   = 8'h09;  // first of the control-range whitespace
  localparam logic [7:0] CharCr    = 8'h0D;  // last of the control-range whitespace
  localparam logic [7:0] CharZero  = 8'h30;  // '0'
  localparam logic [7:0] CharNine  = 8'h39;  // '9'
  localparam logic [7:0] CharHexA  = 8'h41;  // 'A'
  localparam logic [7:0] CharHexF  = 8'h46;  // 'F'

  // Sentence types, first character in the low byte
  localparam logic [23:0] TypeCha = 24'h41_48_43;  // "CHA"
  localparam logic [23:0] TypeAcc = 24'h43_43_41;  // "ACC"
  localparam logic [23:0] TypeRev = 24'h56_45_52;  // "REV"
  localparam logic [23:0] TypeSho = 24'h4F_48_53;  // "SHO"
  localparam logic [23:0] TypeRes = 24'h53_45_52;  // "RES"

  localparam logic [7:0] MaxLenReset = 8'd128;

  typedef enum logic [2:0] {
    EV_START = 3'd0,
    EV_CHA   = 3'd1,
    EV_ACC   = 3'd2,
    EV_REV   = 3'd3,
    EV_SHO   = 3'd4,
    EV_RES   = 3'd5,
    EV_ERROR = 3'd6
  } event_e;

  typedef enum logic [3:0] {
    ERR_NONE       = 4'd0,
    ERR_STRAY      = 4'd1,
    ERR_TOO_LONG   = 4'd2,
    ERR_DELIM      = 4'd3,
    ERR_CKSUM_LEN  = 4'd4,
    ERR_CKSUM_CHAR = 4'd5,
    ERR_MISMATCH   = 4'd6,
    ERR_TYPE       = 4'd7,
    ERR_FIELD      = 4'd8
  } cause_e;

  typedef enum logic [1:0] {
    FP_WAIT    = 2'd0,
    FP_PAYLOAD = 2'd1,
    FP_CKSUM   = 2'd2
  } frame_phase_e;

  typedef enum logic [1:0] {
    FLD_SKIP   = 2'd0,
    FLD_DIGITS = 2'd1,
    FLD_DONE   = 2'd2
  } field_phase_e;

endpackage

FILE: rtl/core/xor_checked_sentence_decoder.sv
// A byte accepted into the input register passes through the decode/update logic into
// the result register; while the receiver stalls the result, the byte waits.
// Throughput: one byte per cycle while the receiver does not stall the result
// register; the single pass through the update logic sets it.
// Only '$' and the closing newline (or an error) produce a result word.
// Reset (rst_ni low, asynchronous): parser back to waiting for '$', all state zero,
// max_payload_len back to 128, both word registers empty.
module xor_checked_sentence_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  // byte stream in
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  byte_in_i,
  // config register write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  max_payload_len_i,
  // events out
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  event_type_o,
  output logic [3:0]  error_cause_o,
  output logic [15:0] param_first_o,
  output logic [15:0] param_second_o,
  output logic [15:0] param_third_o
);
  import xcsd_pkg::*;

  // ---------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       advance;
  logic       out_valid_q;

  // Byte moves into the update pass once the result register can take
  // whatever it produces (empty, or being drained this cycle).
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= byte_in_i;
    end
  end

  // ---------------------------------------------------------------
  // Config register: always writable; user (unchecked) must write only while idle
  // ---------------------------------------------------------------
  logic [7:0] max_len_q;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MaxLenReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_len_q <= max_payload_len_i;
    end
  end

  // ---------------------------------------------------------------
  // Parser state
  // ---------------------------------------------------------------
  frame_phase_e       phase_q, phase_d;
  logic [7:0]         count_q, count_d;
  logic [7:0]         xor_q, xor_d;
  logic [23:0]        type_q, type_d;
  logic [2:0]         type_len_q, type_len_d;   // 4 = longer than three chars
  logic [2:0]         fidx_q, fidx_d;           // tokens begun, saturates at 5
  field_phase_e       fphase_q, fphase_d;
  logic               in_tok_q, in_tok_d;
  logic               neg_q, neg_d;
  logic [2:0][15:0]   fval_q, fval_d;
  logic [1:0]         ck_digits_q, ck_digits_d;
  logic [7:0]         ck_q, ck_d;

  // result of this pass
  logic        emit;
  event_e      ev;
  cause_e      cause;
  logic [15:0] p1, p2, p3;

  // helpers
  logic [7:0]   c;
  logic         is_digit, is_space, is_sign, is_hex;
  logic [3:0]   nib;
  logic [2:0]   idx_n;
  field_phase_e fph_n;
  field_phase_e fph_eff;
  logic         neg_n;
  logic [1:0]   slot;
  logic [15:0]  acc10;
  logic         type_ok;
  event_e       type_ev;
  logic [2:0]   need;

  assign c        = in_byte_q;
  assign is_digit = (c >= CharZero) && (c <= CharNine);
  assign is_space = (c == CharSpace) || ((c >= CharTab) && (c <= CharCr));
  assign is_sign  = (c == CharMinus) || (c == CharPlus);
  assign is_hex   = is_digit || ((c >= CharHexA) && (c <= CharHexF));
  // 'A'..'F' have low nibble 1..6, so +9 lands on 10..15
  assign nib      = is_digit ? c[3:0] : (c[3:0] + 4'd9);

  // token bookkeeping as it stands for this byte
  assign idx_n = in_tok_q ? fidx_q : ((fidx_q < 3'd5) ? (fidx_q + 3'd1) : fidx_q);
  assign fph_n = in_tok_q ? fphase_q : FLD_SKIP;
  assign neg_n = in_tok_q ? neg_q : 1'b0;
  assign slot  = 2'(idx_n - 3'd2);
  // first non-blank, non-sign char decides whether digits follow
  assign fph_eff = (fph_n == FLD_SKIP && !is_space && !is_sign)
                 ? (is_digit ? FLD_DIGITS : FLD_DONE) : fph_n;
  // v*10 = v*8 + v*2, wraps at 16 bits
  assign acc10 = {fval_q[slot][12:0], 3'b000} + {fval_q[slot][14:0], 1'b0};

  // type decode for the newline checks
  always_comb begin
    type_ok = 1'b1;
    type_ev = EV_CHA;
    need    = 3'd1;
    unique case (type_q)
      TypeCha: begin type_ev = EV_CHA; need = 3'd1; end
      TypeAcc: begin type_ev = EV_ACC; need = 3'd1; end
      TypeRev: begin type_ev = EV_REV; need = 3'd1; end
      TypeSho: begin type_ev = EV_SHO; need = 3'd2; end
      TypeRes: begin type_ev = EV_RES; need = 3'd3; end
      default: type_ok = 1'b0;
    endcase
  end

  always_comb begin
    phase_d     = phase_q;
    count_d     = count_q;
    xor_d       = xor_q;
    type_d      = type_q;
    type_len_d  = type_len_q;
    fidx_d      = fidx_q;
    fphase_d    = fphase_q;
    in_tok_d    = in_tok_q;
    neg_d       = neg_q;
    fval_d      = fval_q;
    ck_digits_d = ck_digits_q;
    ck_d        = ck_q;
    emit        = 1'b0;
    ev          = EV_ERROR;
    cause       = ERR_NONE;
    p1          = '0;
    p2          = '0;
    p3          = '0;

    unique case (phase_q)
      FP_PAYLOAD: begin
        if (c == CharStart || c == CharEnd) begin
          phase_d = FP_WAIT;
          emit    = 1'b1;
          cause   = ERR_DELIM;
        end else if (c == CharCheck) begin
          phase_d     = FP_CKSUM;
          ck_digits_d = '0;
          ck_d        = '0;
        end else if (count_q >= max_len_q) begin
          phase_d = FP_WAIT;
          emit    = 1'b1;
          cause   = ERR_TOO_LONG;
        end else begin
          count_d = count_q + 8'd1;
          xor_d   = xor_q ^ c;
          if (c == CharComma) begin
            in_tok_d = 1'b0;
          end else begin
            in_tok_d = 1'b1;
            fidx_d   = idx_n;
            fphase_d = fph_n;
            neg_d    = neg_n;
            if (idx_n == 3'd1) begin
              if (type_len_q < 3'd3) begin
                type_d[8*type_len_q[1:0] +: 8] = c;
                type_len_d = type_len_q + 3'd1;
              end else begin
                type_len_d = 3'd4;
              end
            end else if (idx_n >= 3'd2 && idx_n <= 3'd4) begin
              if (fph_n == FLD_SKIP && is_sign) begin
                neg_d    = (c == CharMinus);
                fphase_d = FLD_DIGITS;
              end else if (fph_eff == FLD_DIGITS && is_digit) begin
                fphase_d     = FLD_DIGITS;
                fval_d[slot] = neg_n ? (acc10 - {12'd0, c[3:0]})
                                     : (acc10 + {12'd0, c[3:0]});
              end else begin
                // blank while skipping keeps the phase, else the field is done
                fphase_d = (fph_eff == FLD_SKIP) ? FLD_SKIP : FLD_DONE;
              end
            end
          end
        end
      end

      FP_CKSUM: begin
        if (c == CharEnd) begin
          phase_d = FP_WAIT;
          emit    = 1'b1;
          if (ck_digits_q != 2'd2) begin
            cause = ERR_CKSUM_LEN;
          end else if (ck_q != xor_q) begin
            cause = ERR_MISMATCH;
          end else if (type_len_q != 3'd3 || !type_ok) begin
            cause = ERR_TYPE;
          end else if (fidx_q <= need) begin
            cause = ERR_FIELD;
          end else begin
            ev = type_ev;
            p1 = fval_q[0];
            p2 = (need >= 3'd2) ? fval_q[1] : '0;
            p3 = (need >= 3'd3) ? fval_q[2] : '0;
          end
        end else if (ck_digits_q >= 2'd2) begin
          phase_d = FP_WAIT;
          emit    = 1'b1;
          cause   = ERR_CKSUM_LEN;
        end else if (!is_hex) begin
          phase_d = FP_WAIT;
          emit    = 1'b1;
          cause   = ERR_CKSUM_CHAR;
        end else begin
          ck_d        = {ck_q[3:0], nib};
          ck_digits_d = ck_digits_q + 2'd1;
        end
      end

      default: begin
        // waiting; the unused phase code behaves the same
        emit = 1'b1;
        if (c != CharStart) begin
          phase_d = FP_WAIT;
          cause   = ERR_STRAY;
        end else begin
          ev          = EV_START;
          phase_d     = FP_PAYLOAD;
          count_d     = '0;
          xor_d       = '0;
          type_d      = '0;
          type_len_d  = '0;
          fidx_d      = '0;
          fphase_d    = FLD_SKIP;
          in_tok_d    = 1'b0;
          neg_d       = 1'b0;
          fval_d      = '0;
          ck_digits_d = '0;
          ck_d        = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= FP_WAIT;
      count_q     <= '0;
      xor_q       <= '0;
      type_q      <= '0;
      type_len_q  <= '0;
      fidx_q      <= '0;
      fphase_q    <= FLD_SKIP;
      in_tok_q    <= 1'b0;
      neg_q       <= 1'b0;
      fval_q      <= '0;
      ck_digits_q <= '0;
      ck_q        <= '0;
    end else if (advance) begin
      phase_q     <= phase_d;
      count_q     <= count_d;
      xor_q       <= xor_d;
      type_q      <= type_d;
      type_len_q  <= type_len_d;
      fidx_q      <= fidx_d;
      fphase_q    <= fphase_d;
      in_tok_q    <= in_tok_d;
      neg_q       <= neg_d;
      fval_q      <= fval_d;
      ck_digits_q <= ck_digits_d;
      ck_q        <= ck_d;
    end
  end

  // ---------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------
  logic [2:0]  ev_q;
  logic [3:0]  cause_q;
  logic [15:0] p1_q, p2_q, p3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= emit;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      ev_q    <= ev;
      cause_q <= cause;
      p1_q    <= p1;
      p2_q    <= p2;
      p3_q    <= p3;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign event_type_o   = ev_q;
  assign error_cause_o  = cause_q;
  assign param_first_o  = p1_q;
  assign param_second_o = p2_q;
  assign param_third_o  = p3_q;

endmodule

FILE: rtl/core/xcsd_checker.sv
module xcsd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  event_type_o,
  input logic [3:0]  error_cause_o,
  input logic [15:0] param_first_o,
  input logic [15:0] param_second_o,
  input logic [15:0] param_third_o
);
  import xcsd_pkg::*;

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(event_type_o)
      && $stable(error_cause_o) && $stable(param_first_o)
      && $stable(param_second_o) && $stable(param_third_o))
    else $error("result word changed while stalled");

  a_err_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_type_o == EV_ERROR |-> error_cause_o != ERR_NONE)
    else $error("error event without a cause");

  a_no_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_type_o != EV_ERROR |-> error_cause_o == ERR_NONE)
    else $error("cause set on a non-error event");

  a_zero_params: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_type_o == EV_ERROR || event_type_o == EV_START)
      |-> param_first_o == '0 && param_second_o == '0 && param_third_o == '0)
    else $error("params nonzero on start or error");

  a_one_param: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_type_o == EV_CHA || event_type_o == EV_ACC
      || event_type_o == EV_REV) |-> param_second_o == '0 && param_third_o == '0)
    else $error("unused params nonzero on single-field message");

endmodule

bind xor_checked_sentence_decoder xcsd_checker u_xcsd_checker (.*);

FILE: test/sentence_check_pkg.sv
`timescale 1ns / 1ps

package sentence_check_pkg;
  import xcsd_pkg::*;

  typedef logic [7:0] byte_q_t[$];

  typedef struct packed {
    event_e      ev;
    cause_e      cause;
    logic [15:0] first;
    logic [15:0] second;
    logic [15:0] third;
  } event_word_t;

  // Tracks the decoder's framing and parsing state, one byte at a time,
  // and holds the event words the block owes us.
  class sentence_scoreboard;
    logic [7:0]   limit;
    frame_phase_e phase;
    logic [7:0]   count;
    logic [7:0]   run_xor;
    logic [23:0]  type_chars;
    logic [2:0]   type_len;
    logic [2:0]   token_idx;
    field_phase_e fphase;
    logic         in_token;
    logic         negative;
    logic [15:0]  values[3];
    logic [1:0]   sum_digits;
    logic [7:0]   sum_rx;
    event_word_t  expected[$];
    int           errors;

    function new();
      errors = 0;
      limit  = MaxLenReset;
      phase  = FP_WAIT;
      clear_frame();
    endfunction

    function void clear_frame();
      count      = '0;
      run_xor    = '0;
      type_chars = '0;
      type_len   = '0;
      token_idx  = '0;
      fphase     = FLD_SKIP;
      in_token   = 1'b0;
      negative   = 1'b0;
      values     = '{default: '0};
      sum_digits = '0;
      sum_rx     = '0;
    endfunction

    function void set_limit(logic [7:0] value);
      limit = value;
    endfunction

    function int pending();
      return expected.size();
    endfunction

    function void push_word(event_e ev, cause_e cause,
                            logic [15:0] p0, logic [15:0] p1, logic [15:0] p2);
      event_word_t w;
      w.ev     = ev;
      w.cause  = cause;
      w.first  = p0;
      w.second = p1;
      w.third  = p2;
      expected.push_back(w);
    endfunction

    function void abort(cause_e cause);
      phase = FP_WAIT;
      push_word(EV_ERROR, cause, '0, '0, '0);
    endfunction

    function void note_byte(logic [7:0] c);
      int          slot;
      int          need;
      logic        digit;
      logic [3:0]  nib;
      logic [15:0] v;
      event_e      ev;
      case (phase)
        FP_PAYLOAD: begin
          if (c == CharStart || c == CharEnd) begin
            abort(ERR_DELIM);
            return;
          end
          if (c == CharCheck) begin
            phase      = FP_CKSUM;
            sum_digits = '0;
            sum_rx     = '0;
            return;
          end
          if (count >= limit) begin
            abort(ERR_TOO_LONG);
            return;
          end
          count++;
          run_xor ^= c;
          if (c == CharComma) begin
            in_token = 1'b0;
            return;
          end
          if (!in_token) begin
            in_token = 1'b1;
            if (token_idx < 5) token_idx++;
            fphase   = FLD_SKIP;
            negative = 1'b0;
          end
          if (token_idx == 1) begin
            if (type_len < 3) begin
              type_chars[8*type_len +: 8] = c;
              type_len++;
            end else begin
              type_len = 3'd4;
            end
          end else if (token_idx >= 2 && token_idx <= 4) begin
            slot  = int'(token_idx) - 2;
            digit = (c >= CharZero && c <= CharNine);
            if (fphase == FLD_SKIP) begin
              if (c == CharSpace || (c >= CharTab && c <= CharCr)) return;
              if (c == CharMinus || c == CharPlus) begin
                negative = (c == CharMinus);
                fphase   = FLD_DIGITS;
                return;
              end
              fphase = digit ? FLD_DIGITS : FLD_DONE;
            end
            if (fphase == FLD_DIGITS) begin
              if (digit) begin
                v = values[slot] * 16'd10;
                values[slot] = negative ? v - {12'd0, c[3:0]} : v + {12'd0, c[3:0]};
              end else begin
                fphase = FLD_DONE;
              end
            end
          end
        end
        FP_CKSUM: begin
          if (c == CharEnd) begin
            if (sum_digits != 2'd2) abort(ERR_CKSUM_LEN);
            else if (sum_rx != run_xor) abort(ERR_MISMATCH);
            else if (type_len != 3'd3) abort(ERR_TYPE);
            else begin
              case (type_chars)
                TypeCha: begin ev = EV_CHA; need = 1; end
                TypeAcc: begin ev = EV_ACC; need = 1; end
                TypeRev: begin ev = EV_REV; need = 1; end
                TypeSho: begin ev = EV_SHO; need = 2; end
                TypeRes: begin ev = EV_RES; need = 3; end
                default: begin ev = EV_ERROR; need = 0; end
              endcase
              if (ev == EV_ERROR) abort(ERR_TYPE);
              else if (int'(token_idx) < need + 1) abort(ERR_FIELD);
              else begin
                phase = FP_WAIT;
                push_word(ev, ERR_NONE, values[0], (need >= 2) ? values[1] : 16'd0,
                          (need >= 3) ? values[2] : 16'd0);
              end
            end
          end else if (sum_digits >= 2'd2) begin
            abort(ERR_CKSUM_LEN);
          end else begin
            if (c >= CharZero && c <= CharNine) nib = c[3:0];
            else if (c >= CharHexA && c <= CharHexF) nib = c[3:0] + 4'd9;
            else begin
              abort(ERR_CKSUM_CHAR);
              return;
            end
            sum_rx = {sum_rx[3:0], nib};
            sum_digits++;
          end
        end
        default: begin
          if (c != CharStart) begin
            abort(ERR_STRAY);
          end else begin
            phase = FP_PAYLOAD;
            clear_frame();
            push_word(EV_START, ERR_NONE, '0, '0, '0);
          end
        end
      endcase
    endfunction

    function void check_word(logic [2:0] ev, logic [3:0] cause,
                             logic [15:0] p0, logic [15:0] p1, logic [15:0] p2);
      event_word_t want;
      if (expected.size() == 0) begin
        $error("unexpected event word: event_type %0d error_cause %0d", ev, cause);
        errors++;
        return;
      end
      want = expected.pop_front();
      if (ev !== want.ev) begin
        $error("event_type: expected %0d, got %0d", want.ev, ev);
        errors++;
      end
      if (cause !== want.cause) begin
        $error("error_cause: expected %0d, got %0d", want.cause, cause);
        errors++;
      end
      if (p0 !== want.first) begin
        $error("param_first: expected %0d, got %0d", want.first, p0);
        errors++;
      end
      if (p1 !== want.second) begin
        $error("param_second: expected %0d, got %0d", want.second, p1);
        errors++;
      end
      if (p2 !== want.third) begin
        $error("param_third: expected %0d, got %0d", want.third, p2);
        errors++;
      end
    endfunction
  endclass

endpackage

FILE: test/tb_xor_checked_sentence_decoder.sv
`timescale 1ns / 1ps

module tb_xor_checked_sentence_decoder;
  import xcsd_pkg::*;
  import sentence_check_pkg::*;

  localparam int HOLD_CYCLES    = 300;   // long receiver stall, fills the pipe
  localparam int SETTLE_CYCLES  = 8;     // extra wait in settle() after the last owed word
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no word moving anywhere

  // Frame corruption flavors for generated sentences
  typedef enum int {
    FRAME_GOOD,
    FRAME_BAD_SUM,    // checksum digits valid but wrong value
    FRAME_BAD_HEX,    // non-hex char in second checksum digit
    FRAME_SHORT_SUM,  // only one checksum digit before newline
    FRAME_LONG_SUM,   // three checksum digits
    FRAME_CUT         // no '*' at all, next '$' lands in the payload
  } frame_fault_e;

  logic        clk_i             = 1'b0;
  logic        rst_ni            = 1'b0;
  logic        in_valid_i        = 1'b0;
  logic [7:0]  byte_in_i         = 8'd0;
  logic        cfg_valid_i       = 1'b0;
  logic [7:0]  max_payload_len_i = 8'd0;
  logic        out_ready_i       = 1'b0;
  logic        in_ready_o;
  logic        cfg_ready_o;
  logic        out_valid_o;
  logic [2:0]  event_type_o;
  logic [3:0]  error_cause_o;
  logic [15:0] param_first_o;
  logic [15:0] param_second_o;
  logic [15:0] param_third_o;

  sentence_scoreboard sb;
  bit idle_en  = 1'b1;  // random gaps on both sides; cleared for the last phase
  bit hold_req = 1'b0;  // asks the receiver for one long stall
  int sent_count = 0;

  xor_checked_sentence_decoder uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .byte_in_i         (byte_in_i),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .max_payload_len_i (max_payload_len_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .event_type_o      (event_type_o),
    .error_cause_o     (error_cause_o),
    .param_first_o     (param_first_o),
    .param_second_o    (param_second_o),
    .param_third_o     (param_third_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------
  // Monitors: everything is sampled at the edge, before the NBA updates,
  // so the predictor sees exactly the words that moved at that edge.
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) sb.note_byte(byte_in_i);
  end

  always @(posedge clk_i) begin
    if (rst_ni && cfg_valid_i && cfg_ready_o) sb.set_limit(max_payload_len_i);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_word(event_type_o, error_cause_o, param_first_o, param_second_o,
                    param_third_o);
  end

  // Watchdog: any word on any channel resets the count
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o))
        quiet = 0;
      else
        quiet++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // Receiver: ready in random stretches, random stall bursts, and one long
  // hold on request. The hold is counted here, independent of the sender.
  initial begin
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (idle_en && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk_i);
    end
  end

  // ---------------------------------------------------------------------
  // Sentence building
  // ---------------------------------------------------------------------
  function automatic byte_q_t text(string s);
    byte_q_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    return q;
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] n);
    return (n < 4'd10) ? CharZero + 8'(n) : CharHexA + 8'(n) - 8'd10;
  endfunction

  // Wraps a payload as $payload*HH<LF>, optionally damaged
  function automatic byte_q_t frame(byte_q_t body, frame_fault_e fault);
    byte_q_t    q;
    logic [7:0] sum;
    // just outside the hex ranges, plus lowercase
    logic [7:0] bad_hex[6] = '{8'h2F, 8'h3A, 8'h40, 8'h47, 8'h61, 8'h66};
    sum = 8'd0;
    q.push_back(CharStart);
    foreach (body[i]) begin
      q.push_back(body[i]);
      sum ^= body[i];
    end
    if (fault == FRAME_CUT) return q;
    q.push_back(CharCheck);
    if (fault == FRAME_BAD_SUM) sum ^= 8'(1 << $urandom_range(0, 7));
    q.push_back(hex_char(sum[7:4]));
    case (fault)
      FRAME_BAD_HEX:   q.push_back(bad_hex[$urandom_range(0, 5)]);
      FRAME_SHORT_SUM: ;
      default:         q.push_back(hex_char(sum[3:0]));
    endcase
    if (fault == FRAME_LONG_SUM) q.push_back(hex_char(4'($urandom_range(0, 15))));
    q.push_back(CharEnd);
    return q;
  endfunction

  // Mostly well-formed payloads: a known type and a few numeric fields with
  // random whitespace, signs, digit counts (long ones wrap) and the odd
  // empty field or junk byte.
  function automatic byte_q_t random_body();
    byte_q_t body;
    string   names[5] = '{"CHA", "ACC", "REV", "SHO", "RES"};
    int      nfields;
    case ($urandom_range(0, 11))
      0:       body = text("CH");
      1:       body = text("REVX");
      2:       repeat (3) body.push_back(8'($urandom_range(65, 90)));
      default: body = text(names[$urandom_range(0, 4)]);
    endcase
    nfields = $urandom_range(0, 4);
    repeat (nfields) begin
      body.push_back(CharComma);
      if ($urandom_range(0, 7) == 0) body.push_back(CharComma);
      if ($urandom_range(0, 3) == 0)
        body.push_back($urandom_range(0, 1) ? CharSpace : 8'($urandom_range(CharTab, CharCr)));
      case ($urandom_range(0, 3))
        0:       body.push_back(CharMinus);
        1:       body.push_back(CharPlus);
        default: ;
      endcase
      repeat ($urandom_range(0, 7)) body.push_back(8'($urandom_range(CharZero, CharNine)));
      if ($urandom_range(0, 5) == 0) body.push_back(8'($urandom_range(0, 255)));
    end
    return body;
  endfunction

  // ---------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------
  task automatic send_byte(logic [7:0] b);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    byte_in_i  <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent_count++;
  endtask

  task automatic send_bytes(byte_q_t q);
    foreach (q[i]) send_byte(q[i]);
  endtask

  // Drop valid, wait for every owed word, then let the pipe drain
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [7:0] value);
    cfg_valid_i       <= 1'b1;
    max_payload_len_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_random(int n_bytes);
    int           target;
    frame_fault_e fault;
    target = sent_count + n_bytes;
    while (sent_count < target) begin
      if ($urandom_range(0, 19) == 0) begin
        send_byte(8'($urandom_range(0, 255)));  // line noise
      end else begin
        case ($urandom_range(0, 15))
          0:       fault = FRAME_BAD_SUM;
          1:       fault = FRAME_BAD_HEX;
          2:       fault = FRAME_SHORT_SUM;
          3:       fault = FRAME_LONG_SUM;
          4:       fault = FRAME_CUT;
          default: fault = FRAME_GOOD;
        endcase
        send_bytes(frame(random_body(), fault));
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    byte_q_t pad_body;
    sb = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed, at the reset limit of 128
    send_byte(8'h00);  // stray bytes at both ends of the range
    send_byte(8'hFF);
    send_bytes(frame(text("CHA,5"), FRAME_GOOD));
    send_bytes(frame(text("ACC,-1"), FRAME_GOOD));             // wraps to 65535
    send_bytes(frame(text("REV,\t+65537"), FRAME_GOOD));       // wraps to 1
    send_bytes(frame(text("SHO,,3,x4"), FRAME_GOOD));          // empty field skipped
    send_bytes(frame(text("RES,1, 2,-3,9"), FRAME_GOOD));      // extra field ignored
    send_bytes(frame(text("CHX,1"), FRAME_GOOD));              // unknown type
    send_bytes(frame(text("RES,1,2"), FRAME_GOOD));            // missing field
    send_bytes(frame(text("CHA,1"), FRAME_BAD_SUM));
    send_bytes(frame(text("ACC,2"), FRAME_BAD_HEX));
    send_bytes(frame(text("REV,3"), FRAME_SHORT_SUM));
    send_bytes(frame(text("SHO,4,5"), FRAME_LONG_SUM));
    send_bytes(text("$CH$"));                                   // '$' inside payload
    send_bytes(text("$C\n"));                                   // newline inside payload
    settle();

    // Max limit: exactly 255 payload bytes pass
    write_limit(8'd255);
    pad_body = text("CHA,7");
    repeat (125) pad_body = {pad_body, text(",1")};
    send_bytes(frame(pad_body, FRAME_GOOD));
    run_random(60);
    settle();

    // Min limit: only one payload byte allowed
    write_limit(8'd1);
    send_bytes(frame(text("A"), FRAME_GOOD));
    send_bytes(frame(text("AB"), FRAME_GOOD));
    run_random(30);
    settle();

    // Long receiver hold while strays keep coming: every stray owes a word,
    // so the output side backs up into the input
    write_limit(8'd128);
    hold_req = 1'b1;
    send_byte(CharEnd);  // whatever the state, this ends in waiting
    repeat (40) send_byte(8'h41);
    run_random(80);
    settle();

    // Tight limit so too-long hits often
    write_limit(8'($urandom_range(10, 40)));
    run_random(60);
    settle();

    // Last stretch at full rate, no gaps on either side
    idle_en = 1'b0;
    write_limit(8'($urandom_range(41, 254)));
    run_random(60);
    settle();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
